[src/bbca_pkg.sv]
package bbca_pkg;

  // Fixed field widths of the pixel and result channels.
  localparam int PIX_W      = 8;
  localparam int FRAC_W     = 8;
  localparam int MEAN_W     = 16;
  localparam int ROW_W      = 10;
  localparam int HEIGHT_MAX = 1024;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int RADIUS_W   = 4;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [RADIUS_W-1:0]   RADIUS_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 11'd480;

  // Request operations.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // Control from the sequencer to every channel lane.
  typedef struct packed {
    logic clear;
    logic acc;
    logic start;
  } lane_ctl_t;

endpackage

[src/bbca_ifs.sv]
interface bbca_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, operation, red_in, green_in, blue_in, output ready);
endinterface

interface bbca_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] red_mean;
  logic [15:0] green_mean;
  logic [15:0] blue_mean;
  logic        frame_end;

  modport source (output valid, red_mean, green_mean, blue_mean, frame_end, input ready);
  modport sink   (input valid, red_mean, green_mean, blue_mean, frame_end, output ready);
endinterface

[src/bbca_lane.sv]
module bbca_lane #(
  parameter int SUM_W = 18,
  parameter int CNT_W = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bbca_pkg::lane_ctl_t             ctl,
  input  logic [bbca_pkg::PIX_W-1:0]      pix,
  input  logic [CNT_W-1:0]                count,
  output logic [bbca_pkg::MEAN_W-1:0]     mean,
  output logic                            busy
);

  localparam int DIV_W  = SUM_W + bbca_pkg::FRAC_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [SUM_W-1:0]  sum_r;
  logic [DIV_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_dif;
  logic              fits;

  // One restoring division step: shift in the next dividend bit and try the divisor.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    fits    = rem_sh >= {1'b0, count};
    rem_dif = rem_sh - {1'b0, count};
  end

  // Window sum of this channel.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum_r <= '0;
    end else if (ctl.acc) begin
      sum_r <= sum_r + SUM_W'(pix);
    end
  end

  // Division of the scaled sum by the pixel count, one quotient bit a cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (ctl.start) begin
      step_r <= STEP_W'(DIV_W);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      quo_r <= {sum_r, {bbca_pkg::FRAC_W{1'b0}}};
      rem_r <= '0;
    end else if (step_r != '0) begin
      rem_r <= fits ? rem_dif[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign mean = quo_r[bbca_pkg::MEAN_W-1:0];
  assign busy = step_r != '0;

endmodule

[src/bbca_merge.sv]
module bbca_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [bbca_pkg::MEAN_W-1:0] red_q,
  input  logic [bbca_pkg::MEAN_W-1:0] green_q,
  input  logic [bbca_pkg::MEAN_W-1:0] blue_q,
  input  logic                        last,
  output logic                        free,
  bbca_out_if.source                  out_ch
);

  logic                        valid_r;
  logic [bbca_pkg::MEAN_W-1:0] red_r;
  logic [bbca_pkg::MEAN_W-1:0] green_r;
  logic [bbca_pkg::MEAN_W-1:0] blue_r;
  logic                        last_r;

  // The result register can take a new result when empty or being drained.
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Gather the three channel means into one result.
  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_q;
      green_r <= green_q;
      blue_r  <= blue_q;
      last_r  <= last;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.red_mean   = red_r;
  assign out_ch.green_mean = green_r;
  assign out_ch.blue_mean  = blue_r;
  assign out_ch.frame_end  = last_r;

endmodule

[src/box_blur_clipped_average_top.sv]
// A request that releases a result passes window setup, the read of its clipped window (at
// most 961 pixels for radius 15) through the single read port of the line store, the
// bit-serial division in the channel lanes and the hand-off to the result register; no new
// request is taken until that hand-off. A request without a result leaves the block idle.
// Reset: synchronous, active low; counters clear, registers take radius 1, width 640 and
// height 480. The line store is not cleared.
module box_blur_clipped_average_top #(
  parameter int MAX_RADIUS = 15,
  parameter int MAX_WIDTH  = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bbca_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bbca_pkg::CFG_DATA_W-1:0]   cfg_data,
  bbca_in_if.sink                           in_ch,
  bbca_out_if.source                        out_ch
);

  localparam int STORE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SROW_W     = $clog2(STORE_ROWS);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int RAD_W      = $clog2(MAX_RADIUS + 1);
  localparam int WIN_W      = $clog2(2 * MAX_RADIUS + 2);
  localparam int CNT_W      = 2 * WIN_W;
  localparam int SUM_W      = CNT_W + bbca_pkg::PIX_W;
  localparam int ADDR_W     = $clog2(STORE_ROWS * MAX_WIDTH);
  localparam int POS_W      = COL_W + bbca_pkg::ROW_W + 1;
  localparam int RW         = bbca_pkg::ROW_W + 6;
  localparam int CW         = COL_W + 6;
  localparam int PW         = bbca_pkg::PIX_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_SUM    = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_DSTART = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;

  logic [bbca_pkg::RADIUS_W-1:0]   radius_r;
  logic [bbca_pkg::CFG_DATA_W-1:0] width_r;
  logic [bbca_pkg::CFG_DATA_W-1:0] height_r;

  logic [COL_W-1:0]          in_col_r;
  logic [bbca_pkg::ROW_W-1:0] in_row_r;
  logic [SROW_W-1:0]         in_rmod_r;
  logic [POS_W-1:0]          in_pos_r;
  logic                      in_done_r;
  logic [COL_W-1:0]          out_col_r;
  logic [bbca_pkg::ROW_W-1:0] out_row_r;
  logic [SROW_W-1:0]         out_rmod_r;

  logic [bbca_pkg::ROW_W-1:0] ycur_r, y1_r;
  logic [SROW_W-1:0]         ymod_r;
  logic [COL_W-1:0]          xcur_r, x0_r, x1_r;
  logic [CNT_W-1:0]          count_r;

  logic [3*PW-1:0]           store_mem [STORE_ROWS*MAX_WIDTH];
  logic [3*PW-1:0]           rd_data_r;
  logic                      rd_vld_r;

  // Effective register values.
  logic [5:0]                rad6;
  logic [RAD_W-1:0]          r_eff;
  logic [12:0]               w13;
  logic [WW-1:0]             w_eff;
  logic [bbca_pkg::CFG_DATA_W-1:0] h_eff;

  always_comb begin
    rad6  = (6'(radius_r) > 6'(MAX_RADIUS)) ? 6'(MAX_RADIUS) : 6'(radius_r);
    r_eff = rad6[RAD_W-1:0];
    w13   = 13'(width_r);
    if (w13 == '0) begin
      w13 = 13'd1;
    end else if (w13 > 13'(MAX_WIDTH)) begin
      w13 = 13'(MAX_WIDTH);
    end
    w_eff = w13[WW-1:0];
    h_eff = height_r;
    if (h_eff == '0) begin
      h_eff = 11'd1;
    end else if (h_eff > 11'(bbca_pkg::HEIGHT_MAX)) begin
      h_eff = 11'(bbca_pkg::HEIGHT_MAX);
    end
  end

  // Request acceptance and what it triggers.
  logic in_acc, cfg_hit, pix_take, emit_go, drain_go;
  logic [POS_W-1:0] delay;

  assign in_ch.ready = state_r == S_IDLE;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg_hit     = cfg_we && (cfg_index == bbca_pkg::REG_RADIUS ||
                                  cfg_index == bbca_pkg::REG_WIDTH ||
                                  cfg_index == bbca_pkg::REG_HEIGHT);
  assign delay    = POS_W'(r_eff) * POS_W'(w_eff) + POS_W'(r_eff);
  assign pix_take = in_acc && in_ch.operation == bbca_pkg::OP_PIXEL && !in_done_r;
  assign drain_go = in_acc && in_ch.operation == bbca_pkg::OP_DRAIN && in_done_r;
  assign emit_go  = drain_go || (pix_take && in_pos_r >= delay);

  // Clipped window of the next output.
  logic [RW-1:0] oy_e, re_r, he_r, y0_c, y1_c;
  logic [CW-1:0] ox_e, re_c, we_c, x0_c, x1_c;
  logic [WIN_W-1:0] rows_c, cols_c;
  logic [SROW_W:0] y0mod_w;
  logic [SROW_W-1:0] y0mod_c;
  logic last_c;

  always_comb begin
    oy_e = RW'(out_row_r);
    re_r = RW'(r_eff);
    he_r = RW'(h_eff);
    y0_c = (oy_e >= re_r) ? oy_e - re_r : '0;
    y1_c = (oy_e + re_r < he_r) ? oy_e + re_r : he_r - 1'b1;
    ox_e = CW'(out_col_r);
    re_c = CW'(r_eff);
    we_c = CW'(w_eff);
    x0_c = (ox_e >= re_c) ? ox_e - re_c : '0;
    x1_c = (ox_e + re_c < we_c) ? ox_e + re_c : we_c - 1'b1;
    rows_c = WIN_W'(y1_c - y0_c + 1'b1);
    cols_c = WIN_W'(x1_c - x0_c + 1'b1);
    y0mod_w = (SROW_W+1)'(out_rmod_r) + (SROW_W+1)'(STORE_ROWS) - (SROW_W+1)'(oy_e - y0_c);
    if (y0mod_w >= (SROW_W+1)'(STORE_ROWS)) begin
      y0mod_w = y0mod_w - (SROW_W+1)'(STORE_ROWS);
    end
    y0mod_c = y0mod_w[SROW_W-1:0];
    last_c  = (oy_e == he_r - 1'b1) && (ox_e == we_c - 1'b1);
  end

  // Sequencer over window reads, division and result hand-off.
  logic sum_end, mrg_free, mrg_load;
  logic [2:0] lane_busy;

  assign sum_end  = (xcur_r == x1_r) && (ycur_r == y1_r);
  assign mrg_load = (state_r == S_OUT) && mrg_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (emit_go) state_nxt = S_SETUP;
      S_SETUP:  state_nxt = S_SUM;
      S_SUM:    if (sum_end) state_nxt = S_TAIL;
      S_TAIL:   state_nxt = S_DSTART;
      S_DSTART: state_nxt = S_DIV;
      S_DIV:    if (lane_busy == '0) state_nxt = S_OUT;
      S_OUT:    if (mrg_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_vld_r <= state_r == S_SUM;
    end
  end

  // Configuration registers and frame counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= bbca_pkg::RADIUS_RST;
      width_r    <= bbca_pkg::WIDTH_RST;
      height_r   <= bbca_pkg::HEIGHT_RST;
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_rmod_r  <= '0;
      in_pos_r   <= '0;
      in_done_r  <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_rmod_r <= '0;
    end else if (cfg_hit) begin
      priority case (cfg_index)
        bbca_pkg::REG_RADIUS: radius_r <= cfg_data[bbca_pkg::RADIUS_W-1:0];
        bbca_pkg::REG_WIDTH:  width_r  <= cfg_data;
        default:              height_r <= cfg_data;
      endcase
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_rmod_r  <= '0;
      in_pos_r   <= '0;
      in_done_r  <= 1'b0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_rmod_r <= '0;
    end else begin
      if (pix_take) begin
        in_pos_r <= in_pos_r + 1'b1;
        if (CW'(in_col_r) + 1'b1 >= CW'(w_eff)) begin
          in_col_r <= '0;
          if (RW'(in_row_r) + 1'b1 >= RW'(h_eff)) begin
            in_done_r <= 1'b1;
          end else begin
            in_row_r  <= in_row_r + 1'b1;
            in_rmod_r <= (in_rmod_r == SROW_W'(STORE_ROWS - 1)) ? '0 : in_rmod_r + 1'b1;
          end
        end else begin
          in_col_r <= in_col_r + 1'b1;
        end
      end
      if (mrg_load) begin
        if (last_c) begin
          in_col_r   <= '0;
          in_row_r   <= '0;
          in_rmod_r  <= '0;
          in_pos_r   <= '0;
          in_done_r  <= 1'b0;
          out_col_r  <= '0;
          out_row_r  <= '0;
          out_rmod_r <= '0;
        end else if (ox_e + 1'b1 >= we_c) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + 1'b1;
          out_rmod_r <= (out_rmod_r == SROW_W'(STORE_ROWS - 1)) ? '0 : out_rmod_r + 1'b1;
        end else begin
          out_col_r <= out_col_r + 1'b1;
        end
      end
    end
  end

  // Window cursor.
  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      ycur_r  <= y0_c[bbca_pkg::ROW_W-1:0];
      y1_r    <= y1_c[bbca_pkg::ROW_W-1:0];
      ymod_r  <= y0mod_c;
      xcur_r  <= x0_c[COL_W-1:0];
      x0_r    <= x0_c[COL_W-1:0];
      x1_r    <= x1_c[COL_W-1:0];
      count_r <= CNT_W'(rows_c) * CNT_W'(cols_c);
    end else if (state_r == S_SUM && !sum_end) begin
      if (xcur_r == x1_r) begin
        xcur_r <= x0_r;
        ycur_r <= ycur_r + 1'b1;
        ymod_r <= (ymod_r == SROW_W'(STORE_ROWS - 1)) ? '0 : ymod_r + 1'b1;
      end else begin
        xcur_r <= xcur_r + 1'b1;
      end
    end
  end

  // Line store: written by pixel requests, read one window pixel a cycle.
  logic [ADDR_W-1:0] wr_addr, rd_addr;

  assign wr_addr = ADDR_W'(in_rmod_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_col_r);
  assign rd_addr = ADDR_W'(ymod_r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(xcur_r);

  always_ff @(posedge clk) begin
    if (pix_take) begin
      store_mem[wr_addr] <= {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[rd_addr];
  end

  // One lane per color channel.
  bbca_pkg::lane_ctl_t lane_ctl;
  logic [bbca_pkg::MEAN_W-1:0] lane_mean [3];

  assign lane_ctl.clear = state_r == S_SETUP;
  assign lane_ctl.acc   = rd_vld_r;
  assign lane_ctl.start = state_r == S_DSTART;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    bbca_lane #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (lane_ctl),
      .pix   (rd_data_r[(2-g)*PW +: PW]),
      .count (count_r),
      .mean  (lane_mean[g]),
      .busy  (lane_busy[g])
    );
  end

  bbca_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (mrg_load),
    .red_q   (lane_mean[0]),
    .green_q (lane_mean[1]),
    .blue_q  (lane_mean[2]),
    .last    (last_c),
    .free    (mrg_free),
    .out_ch  (out_ch)
  );

`ifndef ASSERT_OFF
  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> (lane_busy == 3'b000 || lane_busy == 3'b111))
    else $error("channel lanes out of step");

  a_cursor_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SUM |-> (xcur_r <= x1_r && ycur_r <= y1_r && xcur_r >= x0_r))
    else $error("window cursor outside window");

  a_in_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(in_col_r) < CW'(w_eff))
    else $error("input column beyond row width");

  a_load_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_load |=> state_r == S_IDLE && out_ch.valid)
    else $error("result hand-off did not complete");
`endif

endmodule

[sim/tb_box_blur_clipped_average_top.sv]
`timescale 1ns / 1ps
module tb_box_blur_clipped_average_top;

  localparam int STORE_ROWS = 32;
  localparam int STORE_COLS = 1024;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        last;
  } mean_t;

  typedef struct {
    logic       op;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       has_fixed;
    mean_t      fixed;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [bbca_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bbca_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  bbca_in_if in_ch ();
  bbca_out_if out_ch ();

  box_blur_clipped_average_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the blur state.
  logic [23:0] pix_store [STORE_ROWS*STORE_COLS];
  int unsigned rad_q, wid_q, hgt_q;
  int unsigned in_col, in_row, out_col, out_row;
  bit frame_in_done;
  mean_t pending_means[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent = 0;

  function automatic int unsigned eff_r();
    return rad_q > 15 ? 15 : rad_q;
  endfunction
  function automatic int unsigned eff_w();
    return wid_q == 0 ? 1 : (wid_q > 1024 ? 1024 : wid_q);
  endfunction
  function automatic int unsigned eff_h();
    return hgt_q == 0 ? 1 : (hgt_q > 1024 ? 1024 : hgt_q);
  endfunction

  function automatic void restart_frame();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0; frame_in_done = 0;
  endfunction

  // Window mean of the next output position; advances the output counters.
  function automatic mean_t window_mean();
    int unsigned r, w, h, y0, y1, x0, x1, sr, sg, sb, cnt;
    logic [23:0] p;
    mean_t m;
    r = eff_r(); w = eff_w(); h = eff_h();
    y0 = out_row >= r ? out_row - r : 0;
    y1 = out_row + r < h ? out_row + r : h - 1;
    x0 = out_col >= r ? out_col - r : 0;
    x1 = out_col + r < w ? out_col + r : w - 1;
    sr = 0; sg = 0; sb = 0;
    for (int unsigned y = y0; y <= y1; y++)
      for (int unsigned x = x0; x <= x1; x++) begin
        p = pix_store[(y % STORE_ROWS) * STORE_COLS + x];
        sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
      end
    cnt = (y1 - y0 + 1) * (x1 - x0 + 1);
    m.red = 16'((sr * 256) / cnt);
    m.green = 16'((sg * 256) / cnt);
    m.blue = 16'((sb * 256) / cnt);
    m.last = (out_row == h - 1) && (out_col == w - 1);
    if (m.last) restart_frame();
    else if (out_col + 1 >= w) begin
      out_col = 0; out_row++;
    end else out_col++;
    return m;
  endfunction

  // Predict the result of one accepted request; returns 1 if one is due.
  function automatic bit predict_blur(input stim_t s, output mean_t m);
    int unsigned w, pos;
    w = eff_w();
    if (s.op == bbca_pkg::OP_DRAIN) begin
      if (!frame_in_done) return 0;
      m = window_mean();
      return 1;
    end
    if (frame_in_done) return 0;
    pix_store[(in_row % STORE_ROWS) * STORE_COLS + in_col] = {s.r, s.g, s.b};
    pos = in_row * w + in_col;
    if (in_col + 1 >= w) begin
      in_col = 0;
      if (in_row + 1 >= eff_h()) frame_in_done = 1;
      else in_row++;
    end else in_col++;
    if (pos >= eff_r() * w + eff_r()) begin
      m = window_mean();
      return 1;
    end
    return 0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    errors++;
  endtask

  // Result side: random stalls and comparison with the oldest expectation.
  initial begin
    int gap;
    mean_t got, want;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
      got = '{out_ch.red_mean, out_ch.green_mean, out_ch.blue_mean, out_ch.frame_end};
      if (pending_means.size() == 0) report_mismatch("result with nothing expected");
      else begin
        want = pending_means.pop_front();
        if (got.red !== want.red)
          report_mismatch($sformatf("red %h want %h", got.red, want.red));
        if (got.green !== want.green)
          report_mismatch($sformatf("green %h want %h", got.green, want.green));
        if (got.blue !== want.blue)
          report_mismatch($sformatf("blue %h want %h", got.blue, want.blue));
        if (got.last !== want.last)
          report_mismatch($sformatf("frame_end %b want %b", got.last, want.last));
      end
    end
  end

  // Watchdog on cycles without any accepted request or result.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("box_blur_clipped_average_top verification failed");
      $finish;
    end
  end

  // Valid stays up after an acceptance so that a request without a gap can follow.
  task automatic send_request(input stim_t s, input bit no_gap);
    mean_t m;
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= s.op;
    in_ch.red_in <= s.r; in_ch.green_in <= s.g; in_ch.blue_in <= s.b;
    @(posedge clk iff in_ch.ready);
    sent++;
    if (predict_blur(s, m)) begin
      if (s.has_fixed && m !== s.fixed) report_mismatch("directed row disagrees");
      pending_means.push_back(s.has_fixed ? s.fixed : m);
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    wait (pending_means.size() == 0);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bbca_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
    in_ch.valid <= 1'b0;
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[bbca_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      bbca_pkg::REG_RADIUS: rad_q = val & 4'hf;
      bbca_pkg::REG_WIDTH:  wid_q = val & 11'h7ff;
      bbca_pkg::REG_HEIGHT: hgt_q = val & 11'h7ff;
      default: ;
    endcase
    if (idx <= bbca_pkg::REG_HEIGHT) restart_frame();
  endtask

  function automatic stim_t pix(input logic [7:0] r, g, b);
    stim_t s;
    s = '{bbca_pkg::OP_PIXEL, r, g, b, 1'b0, '0};
    return s;
  endfunction

  // One well-formed frame, then drains until its last result; some noise mixed in.
  task automatic send_frame(input bit noisy);
    stim_t s;
    int unsigned n;
    n = eff_w() * eff_h();
    for (int unsigned i = 0; i < n; i++) begin
      s = pix(8'($urandom), 8'($urandom), 8'($urandom));
      if (noisy && $urandom_range(0, 9) == 0) s.op = bbca_pkg::OP_DRAIN;
      send_request(s, 0);
    end
    while (frame_in_done) begin
      s = pix(8'($urandom), 8'($urandom), 8'($urandom));
      s.op = (noisy && $urandom_range(0, 7) == 0) ? bbca_pkg::OP_PIXEL : bbca_pkg::OP_DRAIN;
      send_request(s, $urandom_range(0, 5) == 0);
    end
  endtask

  stim_t directed[$];

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.operation <= bbca_pkg::OP_PIXEL;
    in_ch.red_in <= '0; in_ch.green_in <= '0; in_ch.blue_in <= '0;
    rad_q = bbca_pkg::RADIUS_RST; wid_q = bbca_pkg::WIDTH_RST; hgt_q = bbca_pkg::HEIGHT_RST;
    restart_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Drain while the frame is still arriving is ignored.
    directed.push_back('{bbca_pkg::OP_DRAIN, 8'hff, 8'hff, 8'hff, 1'b0, '0});
    foreach (directed[i]) send_request(directed[i], 0);
    directed.delete();

    // Radius 0 on a 1x1 image: a full-scale pixel comes straight back.
    write_reg(bbca_pkg::REG_RADIUS, 0);
    write_reg(bbca_pkg::REG_WIDTH, 1);
    write_reg(bbca_pkg::REG_HEIGHT, 1);
    directed.push_back('{bbca_pkg::OP_PIXEL, 8'hff, 8'h00, 8'hff, 1'b1,
                         '{16'hff00, 16'h0000, 16'hff00, 1'b1}});
    directed.push_back('{bbca_pkg::OP_PIXEL, 8'h00, 8'hff, 8'h00, 1'b1,
                         '{16'h0000, 16'hff00, 16'h0000, 1'b1}});
    // Large window on a 2x2 frame: everything leaves by drains; ignored pixel too.
    foreach (directed[i]) send_request(directed[i], 0);
    directed.delete();
    wait_idle();
    write_reg(bbca_pkg::REG_RADIUS, 15);
    write_reg(bbca_pkg::REG_WIDTH, 2);
    write_reg(bbca_pkg::REG_HEIGHT, 2);
    directed.push_back(pix(8'hff, 8'hff, 8'hff));
    directed.push_back(pix(8'h00, 8'h00, 8'h00));
    directed.push_back(pix(8'h80, 8'h01, 8'hfe));
    directed.push_back(pix(8'h7f, 8'hfe, 8'h01));
    directed.push_back(pix(8'h55, 8'haa, 8'h55));
    for (int i = 0; i < 4; i++) begin
      directed.push_back('{bbca_pkg::OP_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, '0});
    end
    foreach (directed[i]) send_request(directed[i], 0);
    directed.delete();

    // A write to index 3 in mid-frame has no effect; the frame goes on.
    wait_idle();
    write_reg(bbca_pkg::REG_WIDTH, 0);
    write_reg(bbca_pkg::REG_HEIGHT, 0);
    write_reg(bbca_pkg::REG_RADIUS, 3);
    write_reg(bbca_pkg::REG_WIDTH, 4);
    write_reg(bbca_pkg::REG_HEIGHT, 3);
    send_request(pix(8'h12, 8'h34, 8'h56), 0);
    wait_idle();
    write_reg(2'd3, 11'h7ff);
    send_frame(0);
    wait_idle();

    // A row wider than the largest width is clipped to it.
    write_reg(bbca_pkg::REG_RADIUS, 0);
    write_reg(bbca_pkg::REG_WIDTH, 2047);
    write_reg(bbca_pkg::REG_HEIGHT, 1);
    send_frame(0);
    wait_idle();

    // Random phases over several geometries, extremes among them.
    while (sent < 1450) begin
      case ($urandom_range(1, 5))
        1: begin
          write_reg(bbca_pkg::REG_RADIUS, 1);
          write_reg(bbca_pkg::REG_WIDTH, 1);
          write_reg(bbca_pkg::REG_HEIGHT, $urandom_range(1, 40));
        end
        default: begin
          write_reg(bbca_pkg::REG_RADIUS, $urandom_range(0, 4));
          write_reg(bbca_pkg::REG_WIDTH, $urandom_range(1, 12));
          write_reg(bbca_pkg::REG_HEIGHT, $urandom_range(1, 10));
        end
      endcase
      send_frame($urandom_range(0, 3) == 0);
      // Hold off until every result is back.
      wait_idle();
    end
    write_reg(bbca_pkg::REG_HEIGHT, 1024);
    write_reg(bbca_pkg::REG_WIDTH, 1024);
    write_reg(bbca_pkg::REG_RADIUS, 15);

    wait_idle();
    if (errors == 0) $display("box_blur_clipped_average_top verification clean");
    else $display("box_blur_clipped_average_top verification failed");
    $finish;
  end

endmodule
